[src/ppw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_pkg
// Types and constants shared by the pose progress watchdog modules.
// ----------------------------------------------------------------------------
package ppw_pkg;

  localparam int NUM_W       = 34;
  localparam int CORDIC_W    = 37;
  localparam int ANG_W       = 16;
  localparam int RADIUS_W    = 31;
  localparam int SQ_W        = 2 * RADIUS_W;
  localparam int ANG_TAB_LEN = 24;
  localparam int TAB_IDX_W   = 5;
  // power of two so the pointers wrap by themselves
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [NUM_W-1:0] ONE_Q28   = 34'h0_1000_0000;

  localparam logic [ANG_W-1:0] ANG_TAB [ANG_TAB_LEN] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
  };

  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [1:0] REG_MOVE_RADIUS    = 2'd0;
  localparam logic [1:0] REG_TURN_LIMIT     = 2'd1;
  localparam logic [1:0] REG_TIME_ALLOWANCE = 2'd2;

  localparam logic [RADIUS_W-1:0] MOVE_RADIUS_RST    = 31'd19661;
  localparam logic [ANG_W-1:0]    TURN_LIMIT_RST     = 16'd2086;
  localparam logic [31:0]         TIME_ALLOWANCE_RST = 32'd8000;

  typedef struct packed {
    logic                    action;
    logic [31:0]             pos_x;
    logic [31:0]             pos_y;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
    logic [31:0]             now_ms;
  } work_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] move_radius;
    logic [ANG_W-1:0]    turn_limit;
    logic [31:0]         time_allowance_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_SQX,
    ST_SQY,
    ST_SQR,
    ST_DECIDE
  } state_t;

endpackage

[src/pose_progress_watchdog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_progress_watchdog
// Motion progress watchdog: yaw by CORDIC, baseline pose, stall report.
// ----------------------------------------------------------------------------
// In the back end a check item passes a load step, the CORDIC rotations on a
// single shared rotator, the squarings of the x and y distances and the move
// radius on one shared 31x31 squaring multiplier, and a decide step that waits
// while the result stalls; a clear item goes from load to decide. The front end
// registers the quaternion products and keeps accepting into a two-entry queue
// while the back end works. One result item per input item, in order.
module pose_progress_watchdog #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic               action,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic [31:0]        now_ms,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               progress_ok,
  output logic               baseline_renewed
);
  import ppw_pkg::*;

  cfg_t  cfg;
  logic  cfg_wr;
  logic  push;
  work_t push_item;
  logic  q_full;
  logic  q_pop;
  work_t q_item;
  logic  q_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_radius       <= MOVE_RADIUS_RST;
      cfg.turn_limit        <= TURN_LIMIT_RST;
      cfg.time_allowance_ms <= TIME_ALLOWANCE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MOVE_RADIUS:    cfg.move_radius       <= pwdata[RADIUS_W-1:0];
        REG_TURN_LIMIT:     cfg.turn_limit        <= pwdata[ANG_W-1:0];
        REG_TIME_ALLOWANCE: cfg.time_allowance_ms <= pwdata;
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MOVE_RADIUS:    prdata = {1'b0, cfg.move_radius};
      REG_TURN_LIMIT:     prdata = {16'd0, cfg.turn_limit};
      REG_TIME_ALLOWANCE: prdata = cfg.time_allowance_ms;
      default:            prdata = '0;
    endcase
  end

  ppw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .action       (action),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .now_ms       (now_ms),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  ppw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  ppw_back #(
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .progress_ok      (progress_ok),
    .baseline_renewed (baseline_renewed)
  );

endmodule

[src/ppw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_front
// Accepts pose items, forms the quaternion products and the yaw vector.
// ----------------------------------------------------------------------------
module ppw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic                action,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [15:0]  quat_w,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  input  logic [31:0]         now_ms,
  output logic                push,
  output ppw_pkg::work_t      push_item,
  input  logic                q_full
);
  import ppw_pkg::*;

  logic               s_valid;
  logic               s_action;
  logic [31:0]        s_px;
  logic [31:0]        s_py;
  logic [31:0]        s_now;
  logic signed [31:0] p_wz;
  logic signed [31:0] p_xy;
  logic signed [31:0] p_yy;
  logic signed [31:0] p_zz;
  logic               load;
  logic signed [32:0] cross_sum;
  logic signed [32:0] sq_sum;

  assign sample_stall = s_valid && q_full;
  assign load         = sample_valid && !sample_stall;
  assign push         = s_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (load) begin
      s_valid <= 1'b1;
    end else if (push) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_action <= action;
      s_px     <= pos_x;
      s_py     <= pos_y;
      s_now    <= now_ms;
      p_wz     <= quat_w * quat_z;
      p_xy     <= quat_x * quat_y;
      p_yy     <= quat_y * quat_y;
      p_zz     <= quat_z * quat_z;
    end
  end

  assign cross_sum = 33'(p_wz) + 33'(p_xy);
  assign sq_sum    = 33'(p_yy) + 33'(p_zz);

  always_comb begin
    push_item.action = s_action;
    push_item.pos_x  = s_px;
    push_item.pos_y  = s_py;
    push_item.now_ms = s_now;
    push_item.num    = {cross_sum, 1'b0};
    push_item.den    = ONE_Q28 - {sq_sum, 1'b0};
  end

endmodule

[src/ppw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ppw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppw_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output ppw_pkg::work_t pop_item,
  output logic           not_empty
);
  import ppw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("queue pop while empty");

endmodule

[src/ppw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_back
// Yaw rotator, distance check, baseline keeping and the result register.
// ----------------------------------------------------------------------------
module ppw_back #(
  parameter int STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  ppw_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  ppw_pkg::work_t q_item,
  output logic           q_pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic           progress_ok,
  output logic           baseline_renewed
);
  import ppw_pkg::*;

  localparam int ITER_W = $clog2(STEPS);

  state_t                     state;
  state_t                     state_next;
  logic [ITER_W-1:0]          iter;
  logic                       w_action;
  logic [31:0]                w_px;
  logic [31:0]                w_py;
  logic [31:0]                w_now;
  logic                       zero_vec;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic [ANG_W-1:0]           cz;
  logic [31:0]                adx;
  logic [31:0]                ady;
  logic [SQ_W-1:0]            sq_x;
  logic [SQ_W-1:0]            sq_y;
  logic [SQ_W-1:0]            sq_r;

  logic [31:0]                base_x;
  logic [31:0]                base_y;
  logic [ANG_W-1:0]           base_yaw;
  logic [31:0]                base_time;
  logic                       base_valid;

  logic                       fire;
  logic [RADIUS_W-1:0]        mul_a;
  logic [SQ_W-1:0]            mul_p;

  logic signed [CORDIC_W-1:0] x0;
  logic signed [CORDIC_W-1:0] y0;
  logic signed [32:0]         dx;
  logic signed [32:0]         dy;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic [ANG_W-1:0]           yaw;
  logic [ANG_W-1:0]           dyaw;
  logic [ANG_W:0]             mag;
  logic                       turned;
  logic [SQ_W:0]              dist2;
  logic                       moved;
  logic                       renew;
  logic [31:0]                elapsed;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.action == ACT_CLEAR) ? ST_DECIDE : ST_ROT;
        end
      end
      ST_ROT: begin
        if (iter == ITER_W'(STEPS - 1)) begin
          state_next = ST_SQX;
        end
      end
      ST_SQX:    state_next = ST_SQY;
      ST_SQY:    state_next = ST_SQR;
      ST_SQR:    state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    fire  = 1'b0;
    mul_a = cfg.move_radius;
    unique case (state)
      ST_IDLE:   q_pop = q_valid;
      ST_SQX:    mul_a = adx[RADIUS_W-1:0];
      ST_SQY:    mul_a = ady[RADIUS_W-1:0];
      ST_DECIDE: fire  = !result_valid || !result_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item load and the shared datapath
  assign x0 = CORDIC_W'(q_item.den);
  assign y0 = CORDIC_W'(q_item.num);
  assign dx = 33'($signed(q_item.pos_x)) - 33'($signed(base_x));
  assign dy = 33'($signed(q_item.pos_y)) - 33'($signed(base_y));
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;
  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      iter <= '0;
    end else if (state == ST_ROT) begin
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          w_action <= q_item.action;
          w_px     <= q_item.pos_x;
          w_py     <= q_item.pos_y;
          w_now    <= q_item.now_ms;
          zero_vec <= (q_item.num == '0) && (q_item.den == '0);
          adx      <= dx[32] ? 32'(-dx) : dx[31:0];
          ady      <= dy[32] ? 32'(-dy) : dy[31:0];
          if (x0 < 0) begin
            cx <= -x0;
            cy <= -y0;
            cz <= HALF_TURN;
          end else begin
            cx <= x0;
            cy <= y0;
            cz <= '0;
          end
        end
      end
      ST_ROT: begin
        if (cy >= 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + ANG_TAB[TAB_IDX_W'(iter)];
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - ANG_TAB[TAB_IDX_W'(iter)];
        end
      end
      ST_SQX:  sq_x <= mul_p;
      ST_SQY:  sq_y <= mul_p;
      ST_SQR:  sq_r <= mul_p;
      default: ;
    endcase
  end

  // decision
  assign yaw     = zero_vec ? '0 : cz;
  assign dyaw    = yaw - base_yaw;
  assign mag     = dyaw[ANG_W-1] ? ((ANG_W+1)'(1) << ANG_W) - {1'b0, dyaw} : {1'b0, dyaw};
  assign turned  = mag > {1'b0, cfg.turn_limit};
  assign dist2   = {1'b0, sq_x} + {1'b0, sq_y};
  assign moved   = base_valid && ((adx > {1'b0, cfg.move_radius})
                   || (ady > {1'b0, cfg.move_radius})
                   || (dist2 > {1'b0, sq_r}));
  assign renew   = !base_valid || moved || turned;
  assign elapsed = w_now - base_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid <= 1'b0;
    end else if (fire) begin
      if (w_action == ACT_CLEAR) begin
        base_valid <= 1'b0;
      end else if (renew) begin
        base_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x    <= '0;
      base_y    <= '0;
      base_yaw  <= '0;
      base_time <= '0;
    end else if (fire && w_action == ACT_CHECK && renew) begin
      base_x    <= w_px;
      base_y    <= w_py;
      base_yaw  <= yaw;
      base_time <= w_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (w_action == ACT_CLEAR) begin
        progress_ok      <= 1'b0;
        baseline_renewed <= 1'b0;
      end else begin
        progress_ok      <= renew || (elapsed <= cfg.time_allowance_ms);
        baseline_renewed <= renew;
      end
    end
  end

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DECIDE))
    else $error("result appeared outside the decide step");

  a_renew_means_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && baseline_renewed) |-> progress_ok)
    else $error("renewed baseline without progress");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT) |-> (iter <= ITER_W'(STEPS - 1)))
    else $error("rotator ran past its step count");

endmodule
